FILE: design/aftm_pkg.sv
// ---------------------------------------------------------------------------
// aftm_pkg: shared types and constants for the fitted ACES tone map
// Pixel payload structs, fixed-point formats and the matrix/fit coefficients.
// ---------------------------------------------------------------------------
package aftm_pkg;

  localparam int IN_W           = 24;
  localparam int OUT_W          = 16;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC      = 12;
  localparam int WORK_FRAC      = 16;
  localparam int FIT_FRAC       = 20;
  localparam int V_W            = 31;
  localparam int DIV_BITS       = 40;
  localparam int MAG_LIMIT_BITS = 42;
  localparam int Q_W            = 22;
  localparam int IN_FRAC_DEF    = 16;
  localparam int OUT_FRAC_DEF   = 15;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  localparam logic [18:0] K_A1 = 19'd412360;
  localparam logic [31:0] K_A0 = 32'd388853;
  localparam logic [23:0] K_B2 = 24'd16504234;
  localparam logic [22:0] K_B1 = 23'd7263712;
  localparam logic [29:0] K_B0 = 30'd1022550109;

  typedef logic [15:0] coef_in_t;
  typedef logic signed [17:0] coef_out_t;

  typedef struct packed {
    logic [IN_W-1:0] in_comp0;
    logic [IN_W-1:0] in_comp1;
    logic [IN_W-1:0] in_comp2;
  } pixel_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_comp0;
    logic [OUT_W-1:0] out_comp1;
    logic [OUT_W-1:0] out_comp2;
  } pixel_out_t;

  function automatic coef_in_t mat_in(input int r, input int c);
    coef_in_t m [3][3];
    m = '{'{16'd39137, 16'd23238, 16'd3161},
          '{16'd4981,  16'd59529, 16'd1026},
          '{16'd1861,  16'd8771,  16'd54904}};
    return m[r][c];
  endfunction

  function automatic coef_out_t mat_out(input int r, input int c);
    coef_out_t m [3][3];
    m = '{'{18'sd105169, -18'sd34805, -18'sd4828},
          '{-18'sd6690,  18'sd72622,  -18'sd396},
          '{-18'sd214,   -18'sd4768,  18'sd70518}};
    return m[r][c];
  endfunction

endpackage

FILE: design/aces_fitted_tone_map.sv
// ---------------------------------------------------------------------------
// aces_fitted_tone_map: pipelined fitted ACES tone map
// Exposure, input matrix, rational RRT/ODT fit with long division, output
// matrix and clamp to [0,1], one pixel per clock.
// ---------------------------------------------------------------------------
// Usage:
//   Pixel request: drive pixel and pulse start; it is taken at any edge with
//   start high and busy low. busy stays low, so a pixel may enter every cycle.
//   Result: result_valid is high for one cycle with result, after the
//   request passes 7 arithmetic stages, 22 divider stages and 2 output
//   stages. Throughput is one pixel per cycle, set by the fully pipelined
//   divider, which resolves one quotient bit per stage.
//   Results come out in request order; the receiver cannot stall and has
//   to take each result in its strobe cycle.
//   Configuration: cfg_data carries exposure_gain (Q4.12), written when
//   cfg_valid and cfg_ready are high; cfg_ready is always high. Write only
//   while no pixel is in flight.
//   Reset: rst (synchronous) empties the pipeline and sets the gain to 1.0.
// ---------------------------------------------------------------------------
module aces_fitted_tone_map
  import aftm_pkg::*;
#(
  parameter int IN_FRAC_BITS  = IN_FRAC_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pixel_in_t         pixel,
  output logic              result_valid,
  output pixel_out_t        result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [GAIN_W-1:0] cfg_data
);

  localparam int UP     = (IN_FRAC_BITS < WORK_FRAC) ? WORK_FRAC - IN_FRAC_BITS : 0;
  localparam int DN     = (IN_FRAC_BITS > WORK_FRAC) ? IN_FRAC_BITS - WORK_FRAC : 0;
  localparam int PE_W   = IN_W + GAIN_W - GAIN_FRAC;
  localparam int E_W    = PE_W + UP;
  localparam int PI_W   = E_W + 16;
  localparam int ACC_W  = PI_W + 2;
  localparam int DROP   = WORK_FRAC + FIT_FRAC - OUT_FRAC_BITS;
  localparam int REM_W  = MAG_LIMIT_BITS + 1 + FIT_FRAC;
  localparam int LAT    = 7 + Q_W + 2;
  localparam int R_W    = 45;

  logic [GAIN_W-1:0] gain;
  logic [LAT-1:0]    vld;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_valid) begin
      gain <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  logic [IN_W-1:0] in_c [3];
  assign in_c[0] = pixel.in_comp0;
  assign in_c[1] = pixel.in_comp1;
  assign in_c[2] = pixel.in_comp2;

  // stage 1: exposure
  logic [E_W-1:0] e [3];
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      logic [IN_W+GAIN_W-1:0] p;
      logic [PE_W-1:0]        pe;
      p  = in_c[c] * gain;
      pe = p[IN_W+GAIN_W-1:GAIN_FRAC];
      e[c] <= {(E_W)'(pe >> DN)} << UP;
    end
  end

  // stage 2: input matrix products
  logic [PI_W-1:0] pin [3][3];
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        pin[r][c] <= PI_W'(e[c] * mat_in(r, c));
  end

  // stage 3: sum, round, saturate
  logic [V_W-1:0] v [3];
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      logic [ACC_W-1:0] acc;
      logic [ACC_W-1:0] sh;
      acc = ACC_W'(pin[r][0]) + ACC_W'(pin[r][1]) + ACC_W'(pin[r][2])
            + ACC_W'(1 << (WORK_FRAC - 1));
      sh  = acc >> WORK_FRAC;
      v[r] <= (sh > ACC_W'({V_W{1'b1}})) ? {V_W{1'b1}} : V_W'(sh);
    end
  end

  // stage 4: fit products
  logic [V_W-1:0] v4 [3];
  logic [61:0]    sq [3];
  logic [49:0]    va1 [3];
  logic [53:0]    vb1 [3];
  logic [V_W-1:0] t4 [3];
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      logic [54:0] pb;
      logic [55:0] pb2;
      pb  = v[r] * K_B2;
      pb2 = 56'(pb) + 56'(1 << 23);
      v4[r]  <= v[r];
      sq[r]  <= v[r] * v[r];
      va1[r] <= v[r] * K_A1;
      vb1[r] <= v[r] * K_B1;
      t4[r]  <= V_W'(pb2 >> 24);
    end
  end

  // stage 5: numerator magnitude and denominator
  logic [63:0] mag5 [3];
  logic [63:0] den5 [3];
  logic        neg5 [3];
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      logic [61:0] vt;
      logic [63:0] np;
      vt = v4[r] * t4[r];
      np = 64'(sq[r]) + 64'(va1[r] >> 8);
      neg5[r] <= np < 64'(K_A0);
      mag5[r] <= (np < 64'(K_A0)) ? 64'(K_A0) - np : np - 64'(K_A0);
      den5[r] <= 64'(vt) + 64'(vb1[r] >> 8) + 64'(K_B0);
    end
  end

  // stage 6: find the shift that brings the denominator under 2^40
  logic [63:0] mag6 [3];
  logic [63:0] den6 [3];
  logic        neg6 [3];
  logic [4:0]  s6 [3];
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      logic [4:0] s;
      s = '0;
      for (int k = 0; k < 64 - DIV_BITS; k++)
        if ((den5[r] >> k) >= (64'd1 << DIV_BITS)) s = 5'(k + 1);
      s6[r]   <= s;
      mag6[r] <= mag5[r];
      den6[r] <= den5[r];
      neg6[r] <= neg5[r];
    end
  end

  // stage 7: apply shift, clamp magnitude, form dividend
  logic [REM_W-1:0]    rem [Q_W+1][3];
  logic [DIV_BITS-1:0] dd  [Q_W+1][3];
  logic [Q_W-1:0]      qq  [Q_W+1][3];
  logic                ng  [Q_W+1][3];
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      logic [63:0] m;
      logic [63:0] d;
      m = mag6[r] >> s6[r];
      d = den6[r] >> s6[r];
      if (m > (64'd1 << MAG_LIMIT_BITS)) m = 64'd1 << MAG_LIMIT_BITS;
      rem[0][r] <= {m[MAG_LIMIT_BITS:0], {FIT_FRAC{1'b0}}};
      dd[0][r]  <= d[DIV_BITS-1:0];
      qq[0][r]  <= '0;
      ng[0][r]  <= neg6[r];
    end
  end

  // divider: one quotient bit per stage, most significant first
  for (genvar d = 0; d < Q_W; d++) begin : g_div
    localparam int B = Q_W - 1 - d;
    always_ff @(posedge clk) begin
      for (int r = 0; r < 3; r++) begin
        logic [REM_W-1:0] sub;
        sub = REM_W'(dd[d][r]) << B;
        if (rem[d][r] >= sub) begin
          rem[d+1][r] <= rem[d][r] - sub;
          qq[d+1][r]  <= qq[d][r] | (Q_W'(1) << B);
        end else begin
          rem[d+1][r] <= rem[d][r];
          qq[d+1][r]  <= qq[d][r];
        end
        dd[d+1][r] <= dd[d][r];
        ng[d+1][r] <= ng[d][r];
      end
    end
  end

  // output matrix products on signed fit values
  logic signed [Q_W+18:0] pout [3][3];
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      logic signed [Q_W:0] f;
      f = ng[Q_W][c] ? -$signed({1'b0, qq[Q_W][c]}) : $signed({1'b0, qq[Q_W][c]});
      for (int r = 0; r < 3; r++)
        pout[r][c] <= f * mat_out(r, c);
    end
  end

  // sum, round, clamp to [0,1]
  logic [OUT_W-1:0] oc [3];
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      logic signed [R_W-1:0] y;
      logic [R_W-1:0]        rr;
      y = R_W'(pout[r][0]) + R_W'(pout[r][1]) + R_W'(pout[r][2]);
      rr = (R_W'(y) + (R_W'(1) << (DROP - 1))) >> DROP;
      if (y <= 0) begin
        oc[r] <= '0;
      end else if (rr > (R_W'(1) << OUT_FRAC_BITS)) begin
        oc[r] <= OUT_W'(R_W'(1) << OUT_FRAC_BITS);
      end else begin
        oc[r] <= OUT_W'(rr);
      end
    end
  end

  assign result_valid     = vld[LAT-1];
  assign result.out_comp0 = oc[0];
  assign result.out_comp1 = oc[1];
  assign result.out_comp2 = oc[2];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT result_valid)
    else $error("pixel request did not produce a result at the pipeline latency");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    result_valid && (OUT_FRAC_BITS <= 15) |->
      (result.out_comp0 <= OUT_W'(1 << OUT_FRAC_BITS)) &&
      (result.out_comp1 <= OUT_W'(1 << OUT_FRAC_BITS)) &&
      (result.out_comp2 <= OUT_W'(1 << OUT_FRAC_BITS)))
    else $error("result component above 1.0");

  a_gain_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(cfg_valid) && !$past(rst) |-> $stable(gain))
    else $error("exposure gain changed without a write");
`endif

endmodule
